// File: hdl/assert_macros.svh
// Shared assertion macros for the RTL folder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define AST_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off during reset.
`define AST_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/aes_pkg.sv
package aes_pkg;

    localparam int BLK_W     = 128;
    localparam int WORD_W    = 32;
    localparam int KEY_REG_W = 64;
    localparam int RK_ROWS   = 16;
    localparam int ROW_AW    = 4;

    // configuration register indexes
    localparam logic [2:0] REG_KEY_SIZE = 3'd0;
    localparam logic [2:0] REG_KEY_3    = 3'd4;

    // key size codes
    localparam logic [1:0] KS_128 = 2'd0;
    localparam logic [1:0] KS_192 = 2'd1;
    localparam logic [1:0] KS_256 = 2'd2;

    typedef logic [255:0][7:0] t_sbox_tab;

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] r;
        logic [7:0] p;
        r = 8'h00;
        p = a;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) r = r ^ p;
            p = xtime(p);
        end
        return r;
    endfunction

    function automatic logic [7:0] gf_inv(input logic [7:0] x);
        logic [7:0] r;
        logic [7:0] p;
        logic [7:0] e;
        r = 8'h01;
        p = x;
        e = 8'd254;
        for (int i = 0; i < 8; i++) begin
            if (e[i]) r = gmul(r, p);
            p = gmul(p, p);
        end
        return r;
    endfunction

    function automatic logic [7:0] rotl8(input logic [7:0] v, input int n);
        return 8'((v << n) | (v >> (8 - n)));
    endfunction

    function automatic t_sbox_tab gen_sbox(input logic inverse);
        t_sbox_tab fwd;
        t_sbox_tab inv;
        logic [7:0] y;
        for (int x = 0; x < 256; x++) begin
            y = gf_inv(8'(x));
            fwd[x] = y ^ rotl8(y, 1) ^ rotl8(y, 2) ^ rotl8(y, 3) ^ rotl8(y, 4) ^ 8'h63;
        end
        for (int x = 0; x < 256; x++) begin
            inv[fwd[x]] = 8'(x);
        end
        return inverse ? inv : fwd;
    endfunction

    localparam t_sbox_tab SBOX     = gen_sbox(1'b0);
    localparam t_sbox_tab INV_SBOX = gen_sbox(1'b1);

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    function automatic logic [31:0] mix_col(input logic [31:0] w);
        logic [7:0] a0, a1, a2, a3;
        a0 = w[31:24]; a1 = w[23:16]; a2 = w[15:8]; a3 = w[7:0];
        return {xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
                a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
                a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
                xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
    endfunction

    function automatic logic [31:0] inv_mix_col(input logic [31:0] w);
        logic [7:0] a0, a1, a2, a3;
        a0 = w[31:24]; a1 = w[23:16]; a2 = w[15:8]; a3 = w[7:0];
        return {gmul(a0, 8'd14) ^ gmul(a1, 8'd11) ^ gmul(a2, 8'd13) ^ gmul(a3, 8'd9),
                gmul(a0, 8'd9)  ^ gmul(a1, 8'd14) ^ gmul(a2, 8'd11) ^ gmul(a3, 8'd13),
                gmul(a0, 8'd13) ^ gmul(a1, 8'd9)  ^ gmul(a2, 8'd14) ^ gmul(a3, 8'd11),
                gmul(a0, 8'd11) ^ gmul(a1, 8'd13) ^ gmul(a2, 8'd9)  ^ gmul(a3, 8'd14)};
    endfunction

endpackage

// File: hdl/aes_block_cipher.sv
// AES-128/192/256 ECB block cipher, one shared round unit, one round per cycle.
// Nr = 10, 12 or 14. Input is not ready again until the current block has moved to
// the output register; the round unit is reused each round.
// A key register write starts key expansion: forward schedule, then inverse
// schedule, input not ready meanwhile.
// Reset (i_rst_n low, synchronous) clears key registers and control; key rows undefined.
`include "assert_macros.svh"

module aes_block_cipher (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_wr_en,
    input  logic [2:0]   i_cfg_addr,
    input  logic [63:0]  i_cfg_wr_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,  // block_high[63:0], block_low[127:64]
    input  logic [0:0]   s_axis_tuser,  // cmd[0]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata   // out_high[63:0], out_low[127:64]
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ARK  = 3'd1;
    localparam logic [2:0] S_RND  = 3'd2;
    localparam logic [2:0] S_DONE = 3'd3;
    localparam logic [2:0] S_EXP  = 3'd4;
    localparam logic [2:0] S_DRD  = 3'd5;
    localparam logic [2:0] S_DWR  = 3'd6;

    localparam int AW = aes_pkg::ROW_AW;
    localparam int BW = aes_pkg::BLK_W;
    localparam int WW = aes_pkg::WORD_W;

    logic [2:0]    r_state, n_state;
    logic [1:0]    r_key_size;
    logic [aes_pkg::KEY_REG_W-1:0] r_key [4];

    logic [BW-1:0] r_st, n_st;
    logic          r_dec, n_dec;
    logic [AW-1:0] r_rnd, n_rnd;
    logic [BW-1:0] r_out;
    logic          r_ovalid;

    logic [5:0]    r_wi;
    logic [2:0]    r_kpos;
    logic [7:0]    r_rcon;
    logic [WW-1:0] r_win [8];
    logic [95:0]   r_row;
    logic [AW-1:0] r_dr;

    logic [BW-1:0] enc_mem [aes_pkg::RK_ROWS];
    logic [BW-1:0] dec_mem [aes_pkg::RK_ROWS];
    logic [BW-1:0] r_erd, r_drd;

    logic [3:0]    w_nk;
    logic [AW-1:0] w_nr;
    logic [5:0]    w_total;
    logic          w_cfg_key;
    logic          w_in_acc;

    assign w_nk    = (r_key_size == aes_pkg::KS_128) ? 4'd4 :
                     (r_key_size == aes_pkg::KS_192) ? 4'd6 : 4'd8;
    assign w_nr    = w_nk + 4'd6;
    assign w_total = {w_nr + 4'd1, 2'b00};
    assign w_cfg_key = i_cfg_wr_en && (i_cfg_addr <= aes_pkg::REG_KEY_3);
    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {r_out[63:0], r_out[127:64]};

    // ---------------- key expansion word ----------------
    logic [WW-1:0] w_prev_nk, w_tmp, w_new;
    logic [63:0]   w_khalf;

    always_comb begin
        case (w_nk)
            4'd4:    w_prev_nk = r_win[3];
            4'd6:    w_prev_nk = r_win[5];
            default: w_prev_nk = r_win[7];
        endcase
        w_khalf = r_key[r_wi[2:1]];
        w_tmp   = r_win[0];
        if (r_kpos == 3'd0) begin
            w_tmp = aes_pkg::sub_word({r_win[0][23:0], r_win[0][31:24]}) ^ {r_rcon, 24'h0};
        end else if (w_nk == 4'd8 && r_kpos == 3'd4) begin
            w_tmp = aes_pkg::sub_word(r_win[0]);
        end
        if (r_wi < 6'(w_nk)) begin
            w_new = r_wi[0] ? w_khalf[31:0] : w_khalf[63:32];
        end else begin
            w_new = w_prev_nk ^ w_tmp;
        end
    end

    // ---------------- shared round unit ----------------
    logic [BW-1:0] w_rk, w_sh, w_mx, w_rnd_out;
    logic          w_last;

    assign w_rk   = r_dec ? r_drd : r_erd;
    assign w_last = (r_rnd == w_nr);

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                if (r_dec) begin
                    w_sh[127-8*(4*c+r) -: 8] =
                        aes_pkg::INV_SBOX[r_st[127-8*(4*((c-r+4)%4)+r) -: 8]];
                end else begin
                    w_sh[127-8*(4*c+r) -: 8] =
                        aes_pkg::SBOX[r_st[127-8*(4*((c+r)%4)+r) -: 8]];
                end
            end
        end
        for (int c = 0; c < 4; c++) begin
            w_mx[127-32*c -: 32] = r_dec ? aes_pkg::inv_mix_col(w_sh[127-32*c -: 32])
                                         : aes_pkg::mix_col(w_sh[127-32*c -: 32]);
        end
        w_rnd_out = (w_last ? w_sh : w_mx) ^ w_rk;
    end

    // inverse schedule row: InvMixColumns on inner rounds
    logic [BW-1:0] w_drow;
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            w_drow[127-32*c -: 32] = aes_pkg::inv_mix_col(r_erd[127-32*c -: 32]);
        end
        if (r_dr == '0 || r_dr == w_nr) w_drow = r_erd;
    end

    // ---------------- key row memories ----------------
    logic          w_ewe, w_dwe;
    logic [AW-1:0] w_eraddr, w_craddr;

    assign w_ewe = (r_state == S_EXP) && (r_wi[1:0] == 2'b11);
    assign w_dwe = (r_state == S_DWR);

    always_comb begin
        case (r_state)
            S_ARK:   w_craddr = AW'(1);
            S_RND:   w_craddr = w_last ? r_rnd : r_rnd + AW'(1);
            default: w_craddr = '0;
        endcase
        w_eraddr = (r_state == S_DRD) ? w_nr - r_dr : w_craddr;
    end

    always_ff @(posedge i_clk) begin
        if (w_ewe) enc_mem[r_wi[5:2]] <= {r_row, w_new};
        if (w_dwe) dec_mem[r_dr] <= w_drow;
        r_erd <= enc_mem[w_eraddr];
        r_drd <= dec_mem[w_craddr];
    end

    // ---------------- sequencer ----------------
    always_comb begin
        n_state = r_state;
        n_st    = r_st;
        n_dec   = r_dec;
        n_rnd   = r_rnd;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_st    = {s_axis_tdata[63:0], s_axis_tdata[127:64]};
                    n_dec   = s_axis_tuser[0];
                    n_state = S_ARK;
                end
            end
            S_ARK: begin
                n_st    = r_st ^ w_rk;
                n_rnd   = AW'(1);
                n_state = S_RND;
            end
            S_RND: begin
                n_st = w_rnd_out;
                if (w_last) n_state = S_DONE;
                else        n_rnd = r_rnd + AW'(1);
            end
            S_DONE: begin
                if (!r_ovalid || m_axis_tready) n_state = S_IDLE;
            end
            S_EXP: begin
                if (r_wi == w_total - 6'd1) n_state = S_DRD;
            end
            S_DRD: n_state = S_DWR;
            S_DWR: begin
                n_state = (r_dr == w_nr) ? S_IDLE : S_DRD;
            end
            default: n_state = S_IDLE;
        endcase
        // restart the schedule on any key register write
        if (w_cfg_key) n_state = S_EXP;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_key_size <= '0;
            for (int k = 0; k < 4; k++) r_key[k] <= '0;
            r_ovalid   <= 1'b0;
            r_wi       <= '0;
            r_kpos     <= '0;
            r_rcon     <= 8'h01;
            r_dr       <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                if (i_cfg_addr == aes_pkg::REG_KEY_SIZE) begin
                    r_key_size <= i_cfg_wr_data[1:0];
                end else if (i_cfg_addr <= aes_pkg::REG_KEY_3) begin
                    r_key[2'(i_cfg_addr - 3'd1)] <= i_cfg_wr_data;
                end
            end
            if (r_state == S_DONE && (!r_ovalid || m_axis_tready)) r_ovalid <= 1'b1;
            else if (m_axis_tready)                                 r_ovalid <= 1'b0;

            if (w_cfg_key) begin
                r_wi   <= '0;
                r_kpos <= '0;
                r_rcon <= 8'h01;
                r_dr   <= '0;
            end else if (r_state == S_EXP) begin
                r_wi   <= r_wi + 6'd1;
                r_kpos <= (4'(r_kpos) == w_nk - 4'd1) ? 3'd0 : r_kpos + 3'd1;
                if (r_wi >= 6'(w_nk) && r_kpos == 3'd0) r_rcon <= aes_pkg::xtime(r_rcon);
            end else if (r_state == S_DWR) begin
                r_dr <= r_dr + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_st  <= n_st;
        r_dec <= n_dec;
        r_rnd <= n_rnd;
        if (r_state == S_DONE && (!r_ovalid || m_axis_tready)) r_out <= r_st;
        if (r_state == S_EXP) begin
            r_row <= {r_row[63:0], w_new};
            r_win[0] <= w_new;
            for (int k = 1; k < 8; k++) r_win[k] <= r_win[k-1];
        end
    end

    `AST_NXT(a_acc_ark, w_in_acc && !w_cfg_key, r_state == S_ARK, "accept did not start cipher")
    `AST_IMP(a_rnd_rng, r_state == S_RND, r_rnd != '0 && r_rnd <= w_nr, "round count out of range")
    `AST_IMP(a_exp_rng, r_state == S_EXP, r_wi < w_total, "schedule index past end")
    `AST_IMP(a_kpos_rng, r_state == S_EXP, 4'(r_kpos) < w_nk, "key position past Nk")

endmodule
